// ===== rtl/ddpu_pkg.sv =====
// shared types, constants and tables of the pose update block
package ddpu_pkg;

  // rotation iterations, and counter width over them
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);

  // rotator datapath width and prescaled start vector (0.60725293 in q2.30)
  localparam int ROT_W = 33;
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef enum logic [1:0] {
    OP_DRIVE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RESTORE = 2'd2,
    OP_LOAD    = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_MIN_SPEED = 2'd1;
  localparam logic [1:0] REG_TURN_GAIN = 2'd2;
  localparam logic [1:0] REG_STEP_GAIN = 2'd3;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } rot_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ROT_W-1:0] cos_v;
    logic signed [ROT_W-1:0] sin_v;
  } rot_rsp_t;

  // arctangent of 2^-i as a binary angle, 2^31 per half turn
  function automatic logic signed [ROT_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ROT_W-1:0] v;
    case (idx)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ddpu_cordic.sv =====
// iterative cordic rotator giving cosine and sine of a binary angle
module ddpu_cordic (
  input  logic                clk,
  input  logic                rst,
  input  ddpu_pkg::rot_req_t  req,
  output ddpu_pkg::rot_rsp_t  rsp
);

  logic                                busy;
  logic                                done;
  logic [ddpu_pkg::CNT_W-1:0]          cnt;
  logic signed [ddpu_pkg::ROT_W-1:0]   x;
  logic signed [ddpu_pkg::ROT_W-1:0]   y;
  logic signed [ddpu_pkg::ROT_W-1:0]   z;
  logic                                neg;

  logic                                neg_init;
  logic [31:0]                         z_init;
  logic [4:0]                          idx;
  logic signed [ddpu_pkg::ROT_W-1:0]   xs;
  logic signed [ddpu_pkg::ROT_W-1:0]   ys;
  logic signed [ddpu_pkg::ROT_W-1:0]   atan;
  logic signed [ddpu_pkg::ROT_W-1:0]   x_next;
  logic signed [ddpu_pkg::ROT_W-1:0]   y_next;
  logic signed [ddpu_pkg::ROT_W-1:0]   z_next;

  // left half plane: turn by half a turn, negate at the end
  always_comb begin
    neg_init = (req.angle[15:14] == 2'd1) || (req.angle[15:14] == 2'd2);
    z_init   = {req.angle[15] ^ neg_init, req.angle[14:0], 16'h0000};
  end

  always_comb begin
    idx  = 5'(cnt);
    xs   = x >>> idx;
    ys   = y >>> idx;
    atan = ddpu_pkg::atan_entry(idx);
    if (!z[ddpu_pkg::ROT_W-1]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= ddpu_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= {z_init[31], z_init};
        neg  <= neg_init;
      end else if (busy) begin
        x   <= x_next;
        y   <= y_next;
        z   <= z_next;
        cnt <= cnt + 1'b1;
        if (cnt == ddpu_pkg::CNT_W'(ddpu_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.cos_v = neg ? -x : x;
  assign rsp.sin_v = neg ? -y : y;

endmodule

// ===== rtl/differential_drive_pose_update.sv =====
// top level: dead-reckoning pose of a two-wheeled robot
//
// one item in, one result out. input channel in_valid/in_ready carries the
// opcode and its operands; output channel out_valid/out_ready carries the
// pose and wheel speeds after that item. registers are written through
// cfg_write/cfg_index/cfg_data; the user must do so only while the block
// is idle, which the block does not enforce. from S_EXEC, restore and load
// go to S_DONE, drive passes S_DRV_L and S_DRV_FIN, and advance passes
// S_ADV_STEP to S_MFIN2. the rotator takes one iteration a cycle and a
// single shared multiplier serves the speed scaling, both gains and the four
// partial products of the position step. in_ready is high only in the idle
// state, so one item is in work at a time; the next item can be taken in the
// cycle after a result is formed. the result sits in an output register, so
// a new item is accepted while it waits; if the receiver is still stalling
// when the following result is due, the sequencer holds in its final state
// until the register frees. reset (synchronous, active high) clears pose,
// saved pose and wheel speeds, loads register defaults and drops out_valid.
module differential_drive_pose_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [15:0]        right_forward,
  input  logic [15:0]        right_reverse,
  input  logic [15:0]        left_forward,
  input  logic [15:0]        left_reverse,
  input  logic signed [31:0] load_x,
  input  logic signed [31:0] load_y,
  input  logic [15:0]        load_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic signed [15:0] right_speed,
  output logic signed [15:0] left_speed
);

  // sequencer states
  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_EXEC     = 14'h0002,
    S_DRV_L    = 14'h0004,
    S_DRV_FIN  = 14'h0008,
    S_ADV_STEP = 14'h0010,
    S_ADV_ROT  = 14'h0020,
    S_ROT_WAIT = 14'h0040,
    S_MXL      = 14'h0080,
    S_MXH      = 14'h0100,
    S_MYL      = 14'h0200,
    S_MYH      = 14'h0400,
    S_MFIN     = 14'h0800,
    S_MFIN2    = 14'h1000,
    S_DONE     = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [14:0]        max_speed;
  logic signed [15:0] min_speed;
  logic [15:0]        turn_gain;
  logic [15:0]        step_gain;

  // architectural state
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic [15:0]        cur_heading;
  logic signed [31:0] saved_x;
  logic signed [31:0] saved_y;
  logic [15:0]        saved_heading;
  logic signed [15:0] right_wheel;
  logic signed [15:0] left_wheel;

  // item held for the sequencer
  ddpu_pkg::opcode_t  op;
  logic [15:0]        rf;
  logic [15:0]        rr;
  logic [15:0]        lf;
  logic [15:0]        lr;
  logic signed [31:0] lx;
  logic signed [31:0] ly;
  logic [15:0]        lh;

  // shared multiplier and its accumulator
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] prod;
  logic signed [61:0] acc;
  logic signed [24:0] step;

  logic signed [16:0] diff_r;
  logic signed [16:0] diff_l;
  logic signed [16:0] wheel_diff;
  logic signed [16:0] wheel_sum;
  logic signed [43:0] turn_round;
  logic signed [43:0] step_round;
  logic signed [61:0] prod_ext;
  logic signed [61:0] prod_hi;
  logic               out_free;

  ddpu_pkg::rot_req_t rot_req;
  ddpu_pkg::rot_rsp_t rot_rsp;

  localparam logic signed [61:0] HALF_Q30 = 62'sd536870912;

  // round half up then clamp, upper bound tested first
  function automatic logic signed [15:0] clamp_speed(
    input logic signed [43:0] p,
    input logic [14:0]        mx,
    input logic signed [15:0] mn
  );
    logic signed [43:0] r;
    logic signed [28:0] s;
    logic signed [28:0] mxe;
    logic signed [28:0] mne;
    logic signed [15:0] res;
    r   = p + 44'sd16384;
    s   = $signed(r[43:15]);
    mxe = $signed({14'b0, mx});
    mne = $signed({{13{mn[15]}}, mn});
    if (s > mxe) begin
      res = $signed({1'b0, mx});
    end else if (s < mne) begin
      res = mn;
    end else begin
      res = s[15:0];
    end
    return res;
  endfunction

  ddpu_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (rot_req),
    .rsp (rot_rsp)
  );

  assign rot_req.start = (state == S_ADV_ROT);
  assign rot_req.angle = cur_heading;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign diff_r     = $signed({1'b0, rf}) - $signed({1'b0, rr});
  assign diff_l     = $signed({1'b0, lf}) - $signed({1'b0, lr});
  assign wheel_diff = {right_wheel[15], right_wheel} - {left_wheel[15], left_wheel};
  assign wheel_sum  = {right_wheel[15], right_wheel} + {left_wheel[15], left_wheel};
  assign turn_round = prod + 44'sd128;
  assign step_round = prod + 44'sd256;
  assign prod_ext   = {{18{prod[43]}}, prod};
  assign prod_hi    = {{2{prod[43]}}, prod, 16'h0000};

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_EXEC: begin
        if (op == ddpu_pkg::OP_DRIVE) begin
          mul_a = {{9{diff_r[16]}}, diff_r};
          mul_b = {3'b0, max_speed};
        end else begin
          mul_a = {{9{wheel_diff[16]}}, wheel_diff};
          mul_b = {2'b0, turn_gain};
        end
      end
      S_DRV_L: begin
        mul_a = {{9{diff_l[16]}}, diff_l};
        mul_b = {3'b0, max_speed};
      end
      S_ADV_STEP: begin
        mul_a = {{9{wheel_sum[16]}}, wheel_sum};
        mul_b = {2'b0, step_gain};
      end
      // cosine and sine split into low unsigned and high signed halves
      S_MXL: begin
        mul_a = {step[24], step};
        mul_b = {2'b0, rot_rsp.cos_v[15:0]};
      end
      S_MXH: begin
        mul_a = {step[24], step};
        mul_b = {rot_rsp.cos_v[32], rot_rsp.cos_v[32:16]};
      end
      S_MYL: begin
        mul_a = {step[24], step};
        mul_b = {2'b0, rot_rsp.sin_v[15:0]};
      end
      S_MYH: begin
        mul_a = {step[24], step};
        mul_b = {rot_rsp.sin_v[32], rot_rsp.sin_v[32:16]};
      end
      S_IDLE, S_DRV_FIN, S_ADV_ROT, S_ROT_WAIT, S_MFIN, S_MFIN2, S_DONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op)
          ddpu_pkg::OP_DRIVE:   state_next = S_DRV_L;
          ddpu_pkg::OP_ADVANCE: state_next = S_ADV_STEP;
          ddpu_pkg::OP_RESTORE, ddpu_pkg::OP_LOAD: state_next = S_DONE;
          default:              state_next = S_DONE;
        endcase
      end
      S_DRV_L:    state_next = S_DRV_FIN;
      S_DRV_FIN:  state_next = S_DONE;
      S_ADV_STEP: state_next = S_ADV_ROT;
      S_ADV_ROT:  state_next = S_ROT_WAIT;
      S_ROT_WAIT: begin
        if (rot_rsp.done) begin
          state_next = S_MXL;
        end
      end
      S_MXL:   state_next = S_MXH;
      S_MXH:   state_next = S_MYL;
      S_MYL:   state_next = S_MYH;
      S_MYH:   state_next = S_MFIN;
      S_MFIN:  state_next = S_MFIN2;
      S_MFIN2: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= 15'd16384;
      min_speed <= -16'sd16384;
      turn_gain <= 16'd256;
      step_gain <= 16'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ddpu_pkg::REG_MAX_SPEED: max_speed <= cfg_data[14:0];
        ddpu_pkg::REG_MIN_SPEED: min_speed <= $signed(cfg_data);
        ddpu_pkg::REG_TURN_GAIN: turn_gain <= cfg_data;
        ddpu_pkg::REG_STEP_GAIN: step_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= ddpu_pkg::opcode_t'(opcode);
      rf <= right_forward;
      rr <= right_reverse;
      lf <= left_forward;
      lr <= left_reverse;
      lx <= load_x;
      ly <= load_y;
      lh <= load_heading;
    end
  end

  // datapath of the shared unit
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_ADV_ROT: step <= step_round[33:9];
      S_MXH:     acc  <= prod_ext + HALF_Q30;
      S_MYL:     acc  <= acc + prod_hi;
      S_MYH:     acc  <= prod_ext + HALF_Q30;
      S_MFIN:    acc  <= acc + prod_hi;
      default: ;
    endcase
  end

  // pose and wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      cur_heading   <= '0;
      saved_x       <= '0;
      saved_y       <= '0;
      saved_heading <= '0;
      right_wheel   <= '0;
      left_wheel    <= '0;
    end else begin
      unique case (state)
        S_EXEC: begin
          unique case (op)
            ddpu_pkg::OP_ADVANCE: begin
              saved_x       <= cur_x;
              saved_y       <= cur_y;
              saved_heading <= cur_heading;
            end
            ddpu_pkg::OP_RESTORE: begin
              cur_x       <= saved_x;
              cur_y       <= saved_y;
              cur_heading <= saved_heading;
            end
            ddpu_pkg::OP_LOAD: begin
              cur_x         <= lx;
              cur_y         <= ly;
              cur_heading   <= lh;
              saved_x       <= lx;
              saved_y       <= ly;
              saved_heading <= lh;
            end
            default: ;
          endcase
        end
        S_DRV_L:    right_wheel <= clamp_speed(prod, max_speed, min_speed);
        S_DRV_FIN:  left_wheel  <= clamp_speed(prod, max_speed, min_speed);
        S_ADV_STEP: cur_heading <= cur_heading + turn_round[23:8];
        S_MYH:      cur_x       <= cur_x + acc[61:30];
        S_MFIN2:    cur_y       <= cur_y + acc[61:30];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      pos_x       <= cur_x;
      pos_y       <= cur_y;
      heading     <= cur_heading;
      right_speed <= right_wheel;
      left_speed  <= left_wheel;
    end
  end

endmodule

// ===== rtl/ddpu_port_check.sv =====
// port-level checks of the pose update block, bound to the top level
module ddpu_port_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic [15:0]        heading
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(heading))
    else $error("result changed while stalled");

  // reset drops the output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  // an accepted item keeps the block busy through S_EXEC and the state after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("block ready too soon after an item");

  // no result can appear in the cycle straight after an acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result without work");

endmodule

bind differential_drive_pose_update ddpu_port_check u_port_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pos_x     (pos_x),
  .pos_y     (pos_y),
  .heading   (heading)
);
